// ===== hw/rtl/dsg_pkg.sv =====
package dsg_pkg;

   // field widths
   localparam int POS_W     = 32;
   localparam int MASS_W    = 32;
   localparam int GRAV_W    = 32;
   localparam int FORCE_W   = 48;
   localparam int IN_DATA_W = 96;
   localparam int OUT_DATA_W = 96;

   // default for the position width parameter
   localparam int POS_WIDTH_DEFAULT = 32;

   // datapath widths
   localparam int DIFF_W = POS_W + 1;       // magnitude of a position difference
   localparam int B_W    = 49;              // multiplier operand shifted out bit by bit
   localparam int WIDE_W = 200;             // wide accumulator, divisor and root
   localparam int P_W    = 96;              // product g * ms * mt
   localparam int QUO_W  = FORCE_W;         // quotient bits, top bit marks overflow
   localparam int CNT_W  = 6;

   // iteration counts and fixed scalings
   localparam int SQRT_STEPS = 49;
   localparam int DIV_STEPS  = QUO_W;
   localparam int ONE_BIT    = 96;          // starting power of four for the root
   localparam int R2_SHIFT   = 32;
   localparam int NUM_SHIFT  = 40;
   localparam int CUBE_SHIFT = QUO_W - 1;

   localparam logic [GRAV_W-1:0]  GRAV_RESET = 32'h0100_0000;
   localparam logic [FORCE_W-1:0] FORCE_MAX  = 48'h7FFF_FFFF_FFFF;
   localparam logic [FORCE_W-1:0] FORCE_MIN  = 48'h8000_0000_0000;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      KIND_LOAD,
      KIND_SOURCE
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [MASS_W-1:0] mass;
      logic              last;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SQRT,
      ST_S2,
      ST_CUBE,
      ST_GM,
      ST_PM,
      ST_NUMX,
      ST_DIVX,
      ST_NUMY,
      ST_DIVY,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/dsg_front.sv =====
module dsg_front #(
   parameter int POS_WIDTH = dsg_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dsg_pkg::IN_DATA_W-1:0]    req_tdata,
   input  logic [0:0]                       req_tuser,
   input  logic                             req_tlast,
   input  logic                             queue_full,
   output logic                             push,
   output dsg_pkg::item_type                push_item
);

   localparam int PW    = (POS_WIDTH > dsg_pkg::POS_W) ? dsg_pkg::POS_W : POS_WIDTH;
   localparam int SHIFT = dsg_pkg::POS_W - PW;

   logic signed [dsg_pkg::POS_W-1:0] sh_x, sh_y;

   // take positions from the low bits and sign-extend
   always_comb begin
      sh_x = $signed(req_tdata[31:0] << SHIFT);
      sh_y = $signed(req_tdata[63:32] << SHIFT);
   end

   // classify and hand over to the queue
   always_comb begin
      push_item.kind  = req_tuser[0] ? dsg_pkg::KIND_SOURCE : dsg_pkg::KIND_LOAD;
      push_item.pos_x = dsg_pkg::POS_W'(sh_x >>> SHIFT);
      push_item.pos_y = dsg_pkg::POS_W'(sh_y >>> SHIFT);
      push_item.mass  = req_tdata[95:64];
      push_item.last  = req_tlast;
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

endmodule

// ===== hw/rtl/dsg_queue.sv =====
module dsg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dsg_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output dsg_pkg::item_type head_item,
   output logic              head_valid
);

   localparam int DEPTH = dsg_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dsg_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));

endmodule

// ===== hw/rtl/dsg_engine.sv =====
module dsg_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [dsg_pkg::GRAV_W-1:0]        grav,
   input  dsg_pkg::item_type                 head_item,
   input  logic                              head_valid,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dsg_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   output logic [0:0]                        rsp_tuser
);

   localparam int WIDE_W  = dsg_pkg::WIDE_W;
   localparam int B_W     = dsg_pkg::B_W;
   localparam int DIFF_W  = dsg_pkg::DIFF_W;
   localparam int FORCE_W = dsg_pkg::FORCE_W;
   localparam int QUO_W   = dsg_pkg::QUO_W;
   localparam int CNT_W   = dsg_pkg::CNT_W;
   localparam int POS_W   = dsg_pkg::POS_W;

   dsg_pkg::state_type state_ff, state_in;

   logic [WIDE_W-1:0]          acc_ff, acc_in, mul_a_ff, mul_a_in;
   logic [WIDE_W-1:0]          root_ff, root_in, cube_ff, cube_in;
   logic [B_W-1:0]             mul_b_ff, mul_b_in;
   logic [dsg_pkg::P_W-1:0]    p_ff, p_in;
   logic [QUO_W-1:0]           quo_ff, quo_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [DIFF_W-1:0]          ax_ff, ax_in, ay_ff, ay_in;
   logic                       neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [dsg_pkg::MASS_W-1:0] mass_ff, mass_in;
   logic                       last_ff, last_in;
   logic [POS_W-1:0]           target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic [dsg_pkg::MASS_W-1:0] target_mass_ff, target_mass_in;
   logic [FORCE_W-1:0]         sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic                       sat_ff, sat_in;
   logic                       out_valid_ff, out_valid_in;
   logic [FORCE_W-1:0]         out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                       out_sat_ff, out_sat_in;

   logic               out_free, emit, mul_done, cnt_zero, sq_ge, div_ge;
   logic [WIDE_W-1:0]  mul_acc, sq_t;
   logic [DIFF_W-1:0]  dx, dy, hx_abs, hy_abs;
   logic               diff_zero;
   logic [FORCE_W-1:0] term_mag, term, sum_sel, sum_sat;
   logic [FORCE_W:0]   sum_wide;
   logic               term_sat, neg_sel, sum_ovf;

   // shared arithmetic
   always_comb begin
      mul_done = (mul_b_ff == '0);
      mul_acc  = mul_b_ff[0] ? acc_ff + mul_a_ff : acc_ff;
      cnt_zero = (cnt_ff == '0);
      sq_t     = root_ff + mul_a_ff;
      sq_ge    = (acc_ff >= sq_t);
      div_ge   = (acc_ff >= mul_a_ff);
      out_free = !out_valid_ff || rsp_tready;
      emit     = (state_ff == dsg_pkg::ST_FINISH) && last_ff && out_free;
   end

   // source minus target for the item at the queue head
   always_comb begin
      dx = {head_item.pos_x[POS_W-1], head_item.pos_x} - {target_x_ff[POS_W-1], target_x_ff};
      dy = {head_item.pos_y[POS_W-1], head_item.pos_y} - {target_y_ff[POS_W-1], target_y_ff};
      hx_abs    = dx[DIFF_W-1] ? -dx : dx;
      hy_abs    = dy[DIFF_W-1] ? -dy : dy;
      diff_zero = (dx == '0) && (dy == '0);
   end

   // signed term from the quotient and saturating sum
   always_comb begin
      term_sat = quo_ff[QUO_W-1];
      term_mag = term_sat ? dsg_pkg::FORCE_MAX : {1'b0, quo_ff[QUO_W-2:0]};
      neg_sel  = (state_ff == dsg_pkg::ST_DIVX) ? neg_x_ff : neg_y_ff;
      sum_sel  = (state_ff == dsg_pkg::ST_DIVX) ? sum_x_ff : sum_y_ff;
      term     = neg_sel ? -term_mag : term_mag;
      sum_wide = {sum_sel[FORCE_W-1], sum_sel} + {term[FORCE_W-1], term};
      sum_ovf  = sum_wide[FORCE_W] ^ sum_wide[FORCE_W-1];
      if (sum_ovf) begin
         sum_sat = sum_wide[FORCE_W] ? dsg_pkg::FORCE_MIN : dsg_pkg::FORCE_MAX;
      end else begin
         sum_sat = sum_wide[FORCE_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dsg_pkg::ST_IDLE: begin
            if (head_valid) begin
               if (head_item.kind == dsg_pkg::KIND_LOAD || diff_zero) begin
                  state_in = dsg_pkg::ST_FINISH;
               end else begin
                  state_in = dsg_pkg::ST_SQX;
               end
            end
         end
         dsg_pkg::ST_SQX:  if (mul_done) state_in = dsg_pkg::ST_SQY;
         dsg_pkg::ST_SQY:  if (mul_done) state_in = dsg_pkg::ST_SQRT;
         dsg_pkg::ST_SQRT: if (cnt_zero) state_in = dsg_pkg::ST_S2;
         dsg_pkg::ST_S2:   if (mul_done) state_in = dsg_pkg::ST_CUBE;
         dsg_pkg::ST_CUBE: if (mul_done) state_in = dsg_pkg::ST_GM;
         dsg_pkg::ST_GM:   if (mul_done) state_in = dsg_pkg::ST_PM;
         dsg_pkg::ST_PM:   if (mul_done) state_in = dsg_pkg::ST_NUMX;
         dsg_pkg::ST_NUMX: if (mul_done) state_in = dsg_pkg::ST_DIVX;
         dsg_pkg::ST_DIVX: if (cnt_zero) state_in = dsg_pkg::ST_NUMY;
         dsg_pkg::ST_NUMY: if (mul_done) state_in = dsg_pkg::ST_DIVY;
         dsg_pkg::ST_DIVY: if (cnt_zero) state_in = dsg_pkg::ST_FINISH;
         dsg_pkg::ST_FINISH: begin
            if (!last_ff || out_free) begin
               state_in = dsg_pkg::ST_IDLE;
            end
         end
         default: state_in = dsg_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop            = 1'b0;
      acc_in         = acc_ff;
      mul_a_in       = mul_a_ff;
      mul_b_in       = mul_b_ff;
      root_in        = root_ff;
      cube_in        = cube_ff;
      p_in           = p_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      neg_x_in       = neg_x_ff;
      neg_y_in       = neg_y_ff;
      mass_in        = mass_ff;
      last_in        = last_ff;
      target_x_in    = target_x_ff;
      target_y_in    = target_y_ff;
      target_mass_in = target_mass_ff;
      sum_x_in       = sum_x_ff;
      sum_y_in       = sum_y_ff;
      sat_in         = sat_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_sat_in     = out_sat_ff;

      unique case (state_ff)
         dsg_pkg::ST_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               last_in = head_item.last;
               if (head_item.kind == dsg_pkg::KIND_LOAD) begin
                  target_x_in    = head_item.pos_x;
                  target_y_in    = head_item.pos_y;
                  target_mass_in = head_item.mass;
                  sum_x_in       = '0;
                  sum_y_in       = '0;
                  sat_in         = 1'b0;
               end else begin
                  ax_in    = hx_abs;
                  ay_in    = hy_abs;
                  neg_x_in = dx[DIFF_W-1];
                  neg_y_in = dy[DIFF_W-1];
                  mass_in  = head_item.mass;
                  acc_in   = '0;
                  mul_a_in = WIDE_W'(hx_abs);
                  mul_b_in = B_W'(hx_abs);
               end
            end
         end
         dsg_pkg::ST_SQX, dsg_pkg::ST_SQY, dsg_pkg::ST_S2, dsg_pkg::ST_CUBE,
         dsg_pkg::ST_GM, dsg_pkg::ST_PM, dsg_pkg::ST_NUMX, dsg_pkg::ST_NUMY: begin
            if (!mul_done) begin
               // shift-add step
               acc_in   = mul_acc;
               mul_a_in = mul_a_ff << 1;
               mul_b_in = mul_b_ff >> 1;
            end else begin
               unique case (state_ff)
                  dsg_pkg::ST_SQX: begin
                     // keep the accumulator so dy squared adds on
                     mul_a_in = WIDE_W'(ay_ff);
                     mul_b_in = B_W'(ay_ff);
                  end
                  dsg_pkg::ST_SQY: begin
                     acc_in   = acc_ff << dsg_pkg::R2_SHIFT;
                     mul_a_in = WIDE_W'(1) << dsg_pkg::ONE_BIT;
                     root_in  = '0;
                     cnt_in   = CNT_W'(dsg_pkg::SQRT_STEPS);
                  end
                  dsg_pkg::ST_S2: begin
                     mul_a_in = acc_ff;
                     mul_b_in = root_ff[B_W-1:0];
                     acc_in   = '0;
                  end
                  dsg_pkg::ST_CUBE: begin
                     cube_in  = acc_ff;
                     mul_a_in = WIDE_W'(grav);
                     mul_b_in = B_W'(mass_ff);
                     acc_in   = '0;
                  end
                  dsg_pkg::ST_GM: begin
                     mul_a_in = acc_ff;
                     mul_b_in = B_W'(target_mass_ff);
                     acc_in   = '0;
                  end
                  dsg_pkg::ST_PM: begin
                     p_in     = acc_ff[dsg_pkg::P_W-1:0];
                     mul_a_in = WIDE_W'(acc_ff[dsg_pkg::P_W-1:0]) << dsg_pkg::NUM_SHIFT;
                     mul_b_in = B_W'(ax_ff);
                     acc_in   = '0;
                  end
                  default: begin
                     // numerator ready, set up the divisor
                     mul_a_in = cube_ff << dsg_pkg::CUBE_SHIFT;
                     quo_in   = '0;
                     cnt_in   = CNT_W'(dsg_pkg::DIV_STEPS);
                  end
               endcase
            end
         end
         dsg_pkg::ST_SQRT: begin
            if (cnt_zero) begin
               mul_a_in = root_ff;
               mul_b_in = root_ff[B_W-1:0];
               acc_in   = '0;
            end else begin
               // one root bit per step
               if (sq_ge) begin
                  acc_in  = acc_ff - sq_t;
                  root_in = (root_ff >> 1) + mul_a_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               mul_a_in = mul_a_ff >> 2;
               cnt_in   = cnt_ff - 1'b1;
            end
         end
         dsg_pkg::ST_DIVX, dsg_pkg::ST_DIVY: begin
            if (cnt_zero) begin
               sat_in = sat_ff || term_sat || sum_ovf;
               if (state_ff == dsg_pkg::ST_DIVX) begin
                  sum_x_in = sum_sat;
                  mul_a_in = WIDE_W'(p_ff) << dsg_pkg::NUM_SHIFT;
                  mul_b_in = B_W'(ay_ff);
                  acc_in   = '0;
               end else begin
                  sum_y_in = sum_sat;
               end
            end else begin
               // one quotient bit per step, top bit flags overflow
               if (div_ge) begin
                  acc_in = acc_ff - mul_a_ff;
                  quo_in = {quo_ff[QUO_W-2:0], 1'b1};
               end else begin
                  quo_in = {quo_ff[QUO_W-2:0], 1'b0};
               end
               mul_a_in = mul_a_ff >> 1;
               cnt_in   = cnt_ff - 1'b1;
            end
         end
         dsg_pkg::ST_FINISH: begin
            if (emit) begin
               out_valid_in = 1'b1;
               out_x_in     = sum_x_ff;
               out_y_in     = sum_y_ff;
               out_sat_in   = sat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dsg_pkg::ST_IDLE;
         out_valid_ff   <= 1'b0;
         target_x_ff    <= '0;
         target_y_ff    <= '0;
         target_mass_ff <= '0;
         sum_x_ff       <= '0;
         sum_y_ff       <= '0;
         sat_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         out_valid_ff   <= out_valid_in;
         target_x_ff    <= target_x_in;
         target_y_ff    <= target_y_in;
         target_mass_ff <= target_mass_in;
         sum_x_ff       <= sum_x_in;
         sum_y_ff       <= sum_y_in;
         sat_ff         <= sat_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      root_ff    <= root_in;
      cube_ff    <= cube_in;
      p_ff       <= p_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      mass_ff    <= mass_in;
      last_ff    <= last_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_sat_ff <= out_sat_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff};
   assign rsp_tuser  = out_sat_ff;

   // pop only with an item at the head
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   // a new result never overwrites one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !emit)
      else $error("result register overwritten");

   // the root trial bit stays a single bit while iterating
   a_root_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsg_pkg::ST_SQRT && !cnt_zero) |-> $onehot(mul_a_ff))
      else $error("root trial bit lost");

   // pop happens only from idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == dsg_pkg::ST_IDLE))
      else $error("pop outside idle");

endmodule

// ===== hw/rtl/direct_sum_gravity_force_2d.sv =====
// channel  direction  handshake             payload
// req      in         req_tvalid/tready     tdata pos_x,pos_y,mass; tuser mode; tlast last
// rsp      out        rsp_tvalid/tready     tdata force_x,force_y; tuser saturated
// csr      in         csr_we                csr_wdata grav_const
//
// a target load or a coincident source body goes from idle straight to finish in the engine
// a source body runs the root, product and quotient states: one shift-add unit runs every
// product a bit per cycle, the root and both quotients one bit per cycle
// synchronous active-high reset clears control state and sets grav_const to 1.0
// a two-entry queue takes items while the engine works; a waiting result stalls
// the engine when the next one is due, and the input side stalls once the queue is full
module direct_sum_gravity_force_2d #(
   parameter int POS_WIDTH = dsg_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dsg_pkg::IN_DATA_W-1:0]   req_tdata,   // pos_x, pos_y, mass
   input  logic [0:0]                      req_tuser,   // mode
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dsg_pkg::OUT_DATA_W-1:0]  rsp_tdata,   // force_x, force_y
   output logic [0:0]                      rsp_tuser,   // saturated
   input  logic                            csr_we,
   input  logic [dsg_pkg::GRAV_W-1:0]      csr_wdata
);

   logic [dsg_pkg::GRAV_W-1:0] grav_ff, grav_in;
   logic              push, pop, queue_full, head_valid;
   dsg_pkg::item_type push_item, head_item;

   // gravitational constant register
   assign grav_in = csr_we ? csr_wdata : grav_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= dsg_pkg::GRAV_RESET;
      end else begin
         grav_ff <= grav_in;
      end
   end

   // front: accept and classify
   dsg_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // queue between front and engine
   dsg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_item  (head_item),
      .head_valid (head_valid)
   );

   // back: force engine and result register
   dsg_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .grav       (grav_ff),
      .head_item  (head_item),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
